@@ design/ise_pkg.sv @@
// ise_pkg: shared types, constants and helpers of the independent set expander.
// No dependencies; used by every module of the block.
package ise_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int ROW_W         = 64;
    localparam int NODE_W        = 6;
    localparam int COUNT_W       = 7;
    localparam int QUEUE_DEPTH   = 2;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    // paddr[2] selects the register slot; slot 0 is node_count
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_START  = 2'd1,
        KIND_EXPAND = 2'd2,
        KIND_NONE   = 2'd3
    } item_kind_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_ENUM = 1'b1
    } queue_op_t;

    // word: row contents for OP_LOAD, base set for OP_ENUM
    // pick: candidates already masked to the nodes in use
    typedef struct packed {
        queue_op_t          op;
        logic [NODE_W-1:0]  idx;
        logic [ROW_W-1:0]   word;
        logic [ROW_W-1:0]   pick;
    } queue_entry_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EMIT = 1'b1
    } back_state_t;

    function automatic logic [NODE_W-1:0] onehot_index(input logic [ROW_W-1:0] oh);
        logic [NODE_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (oh[i])
            begin
                idx = idx | NODE_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ design/ise_front.sv @@
// ise_front: accepts input items, drops those that give no work, and forms queue entries.
// Depends on ise_pkg.
module ise_front #(
    parameter int MAX_NODES = ise_pkg::DEF_MAX_NODES
) (
    input  logic [ise_pkg::COUNT_W-1:0] node_count,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  kind,
    input  logic [ise_pkg::NODE_W-1:0]  row_index,
    input  logic [ise_pkg::ROW_W-1:0]   row_bits,
    input  logic [ise_pkg::ROW_W-1:0]   set_bits,
    input  logic [ise_pkg::ROW_W-1:0]   cand_bits,
    input  logic                        q_full,
    output logic                        q_push,
    output ise_pkg::queue_entry_t       q_entry
);

    localparam logic [ise_pkg::COUNT_W-1:0] MaxCount = ise_pkg::COUNT_W'(MAX_NODES);

    logic [ise_pkg::COUNT_W-1:0] n_eff;
    logic [ise_pkg::ROW_W-1:0]   keep;
    logic                        useful;

    always_comb
    begin
        n_eff = (node_count > MaxCount) ? MaxCount : node_count;
        if (n_eff >= ise_pkg::COUNT_W'(ise_pkg::ROW_W))
        begin
            keep = '1;
        end
        else
        begin
            keep = (ise_pkg::ROW_W'(1) << n_eff[ise_pkg::NODE_W-1:0]) - ise_pkg::ROW_W'(1);
        end
    end

    always_comb
    begin
        q_entry.op   = ise_pkg::OP_ENUM;
        q_entry.idx  = row_index;
        q_entry.word = '0;
        q_entry.pick = '0;
        useful       = 1'b0;
        unique case (ise_pkg::item_kind_t'(kind))
            ise_pkg::KIND_LOAD:
            begin
                q_entry.op   = ise_pkg::OP_LOAD;
                q_entry.word = row_bits;
                useful       = ({1'b0, row_index} < MaxCount);
            end
            ise_pkg::KIND_START:
            begin
                q_entry.pick = keep;
                useful       = (keep != '0);
            end
            ise_pkg::KIND_EXPAND:
            begin
                q_entry.word = set_bits;
                q_entry.pick = cand_bits & keep;
                useful       = ((cand_bits & keep) != '0);
            end
            ise_pkg::KIND_NONE:
            begin
                useful = 1'b0;
            end
            default:
            begin
                useful = 1'b0;
            end
        endcase
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && useful;

endmodule

@@ design/ise_queue.sv @@
// ise_queue: short FIFO of work entries between front and back.
// Depends on ise_pkg.
module ise_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ise_pkg::queue_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  valid,
    output ise_pkg::queue_entry_t head
);

    localparam int Depth = ise_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    ise_pkg::queue_entry_t slots_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CntW'(Depth));
    assign valid   = (count_reg != '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/ise_back.sv @@
// ise_back: adjacency memory, candidate walk and output register.
// Depends on ise_pkg.
module ise_back #(
    parameter int MAX_NODES = ise_pkg::DEF_MAX_NODES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  ise_pkg::queue_entry_t       q_head,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ise_pkg::ROW_W-1:0]   new_set,
    output logic [ise_pkg::ROW_W-1:0]   new_cands,
    output logic [ise_pkg::NODE_W-1:0]  added_node,
    output logic                        last
);

    localparam int AddrW = $clog2(MAX_NODES);

    logic [ise_pkg::ROW_W-1:0] adj_mem [MAX_NODES];

    ise_pkg::back_state_t state_reg, state_next;

    logic [ise_pkg::ROW_W-1:0]  rd_data_reg;
    logic [ise_pkg::ROW_W-1:0]  rem_reg;
    logic [ise_pkg::ROW_W-1:0]  bit_reg;
    logic [ise_pkg::ROW_W-1:0]  base_reg;
    logic                       out_valid_reg;
    logic [ise_pkg::ROW_W-1:0]  new_set_reg;
    logic [ise_pkg::ROW_W-1:0]  new_cands_reg;
    logic [ise_pkg::NODE_W-1:0] added_node_reg;
    logic                       last_reg;

    logic                       out_free;
    logic                       mem_we;
    logic                       rd_en;
    logic                       emit;
    logic [ise_pkg::ROW_W-1:0]  scan_src;
    logic [ise_pkg::ROW_W-1:0]  low_bit;
    logic [ise_pkg::NODE_W-1:0] low_idx;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        scan_src = (state_reg == ise_pkg::BK_IDLE) ? q_head.pick : rem_reg;
        low_bit  = scan_src & (~scan_src + ise_pkg::ROW_W'(1));
        low_idx  = ise_pkg::onehot_index(low_bit);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ise_pkg::BK_IDLE:
            begin
                if (q_valid && q_head.op == ise_pkg::OP_ENUM)
                begin
                    state_next = ise_pkg::BK_EMIT;
                end
            end
            ise_pkg::BK_EMIT:
            begin
                if (out_free && rem_reg == '0)
                begin
                    state_next = ise_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ise_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop  = 1'b0;
        mem_we = 1'b0;
        rd_en  = 1'b0;
        emit   = 1'b0;
        unique case (state_reg)
            ise_pkg::BK_IDLE:
            begin
                q_pop  = q_valid;
                mem_we = q_valid && q_head.op == ise_pkg::OP_LOAD;
                rd_en  = q_valid && q_head.op == ise_pkg::OP_ENUM;
            end
            ise_pkg::BK_EMIT:
            begin
                emit  = out_free;
                rd_en = out_free && rem_reg != '0;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ise_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            adj_mem[q_head.idx[AddrW-1:0]] <= q_head.word;
        end
        if (rd_en)
        begin
            rd_data_reg <= adj_mem[low_idx[AddrW-1:0]];
            rem_reg     <= scan_src & ~low_bit;
            bit_reg     <= low_bit;
        end
        if (state_reg == ise_pkg::BK_IDLE && rd_en)
        begin
            base_reg <= q_head.word;
        end
        if (emit)
        begin
            new_set_reg    <= base_reg | bit_reg;
            new_cands_reg  <= rd_data_reg & rem_reg;
            added_node_reg <= ise_pkg::onehot_index(bit_reg);
            last_reg       <= (rem_reg == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_set    = new_set_reg;
    assign new_cands  = new_cands_reg;
    assign added_node = added_node_reg;
    assign last       = last_reg;

endmodule

@@ design/independent_set_expander_unit.sv @@
// independent_set_expander_unit: top level, APB register and the front/queue/back chain.
// Depends on ise_pkg, ise_front, ise_queue, ise_back.
//
// Load items write one adjacency row; start and expand items emit one result per
// candidate node, lowest node first, with last set on the final one. An item that
// yields nothing (kind 3, empty candidates, load row >= MAX_NODES) is taken and dropped.
// A load only writes its row; a start or expand item with k results (at most
// MAX_NODES) needs its k rows, one per result, from the single read port of the
// adjacency memory, which gives one row per cycle unless the output stalls. A
// two-entry queue lets the front keep taking items while the back end works, and
// the output register lets the next result form while one waits to be taken.
module independent_set_expander_unit #(
    parameter int MAX_NODES = ise_pkg::DEF_MAX_NODES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ise_pkg::PADDR_W-1:0]  paddr,
    input  logic [ise_pkg::PDATA_W-1:0]  pwdata,
    output logic [ise_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   kind,
    input  logic [ise_pkg::NODE_W-1:0]   row_index,
    input  logic [ise_pkg::ROW_W-1:0]    row_bits,
    input  logic [ise_pkg::ROW_W-1:0]    set_bits,
    input  logic [ise_pkg::ROW_W-1:0]    cand_bits,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ise_pkg::ROW_W-1:0]    new_set,
    output logic [ise_pkg::ROW_W-1:0]    new_cands,
    output logic [ise_pkg::NODE_W-1:0]   added_node,
    output logic                         last
);

    logic [ise_pkg::COUNT_W-1:0] node_count_reg;
    logic                        cfg_wr;
    logic                        q_push;
    logic                        q_full;
    logic                        q_pop;
    logic                        q_valid;
    ise_pkg::queue_entry_t       push_entry;
    ise_pkg::queue_entry_t       q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && paddr[2] == ise_pkg::REG_NODE_COUNT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= ise_pkg::NODE_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            node_count_reg <= pwdata[ise_pkg::COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == ise_pkg::REG_NODE_COUNT)
        begin
            prdata = ise_pkg::PDATA_W'(node_count_reg);
        end
    end

    ise_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .node_count (node_count_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .row_index  (row_index),
        .row_bits   (row_bits),
        .set_bits   (set_bits),
        .cand_bits  (cand_bits),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    ise_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    ise_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .new_set    (new_set),
        .new_cands  (new_cands),
        .added_node (added_node),
        .last       (last)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

    a_node_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, added_node} < ise_pkg::COUNT_W'(MAX_NODES)))
        else $error("added node beyond MAX_NODES");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("gap inside a result burst");

endmodule
